// ===== design/integer_to_radix_digits_assert.svh =====
// Assertion macros for the radix digit converter.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

// The property must hold at every clock edge.
`define ITRD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ITRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/itrd_pkg.sv =====
// Shared widths, radix limits and the digit alphabet of the radix digit converter.
// No dependencies.
package itrd_pkg;

	localparam int VALUE_W            = 64;
	localparam int RADIX_W            = 6;
	localparam int DIGIT_W            = 6;
	localparam int CHAR_W             = 7;
	localparam int DEFAULT_VALUE_BITS = 64;
	// quotient bits resolved per cycle by the divide unit
	localparam int DIV_BITS           = 8;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd62;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	localparam logic [DIGIT_W-1:0] DIGITS_DEC   = 6'd10;
	localparam logic [DIGIT_W-1:0] DIGITS_UPPER = 6'd36;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 7'h30;
	localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = 7'h61;

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = CHAR_W'(d);
		if (d < DIGITS_DEC)
			return CHAR_ZERO + dx;
		else if (d < DIGITS_UPPER)
			return CHAR_UPPER_A + dx - CHAR_W'(DIGITS_DEC);
		else
			return CHAR_LOWER_A + dx - CHAR_W'(DIGITS_UPPER);
	endfunction

endpackage

// ===== design/itrd_if.sv =====
// Valid/ready channel interfaces: integer requests in, digit results out.
// Depends on itrd_pkg for the field widths.
interface itrd_value_if import itrd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface itrd_digit_if import itrd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CHAR_W-1:0]  digit_char;
	logic [DIGIT_W-1:0] digit_value;
	logic               last_digit;

	modport source (output valid, output digit_char, output digit_value, output last_digit,
		input ready);
	modport sink   (input valid, input digit_char, input digit_value, input last_digit,
		output ready);
endinterface

// ===== design/integer_to_radix_digits.sv =====
// Radix digit converter: one unsigned integer in, its digits in base 2..62 out, MSD first.
// Flow: an accept, then per digit a full long division by the shared 8-bit-per-cycle
// long-division unit, the digits going LSD first into the digit RAM, then per digit
// out a digit RAM read and the output, MSD first.
// Throughput: one request at a time; ready only when the previous digits are all sent.
// Reset: radix returns to 10, block idle; the digit RAM is not cleared.
module integer_to_radix_digits import itrd_pkg::*; #(
	parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [RADIX_W-1:0]  cfg_wdata,
	itrd_value_if.sink          number,
	itrd_digit_if.source        digits
);

	localparam int PAD_W  = ((VALUE_BITS + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
	localparam int STEPS  = PAD_W / DIV_BITS;
	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int ADDR_W = $clog2(VALUE_BITS);

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_READ, S_SEND} state_t;

	state_t              state_q;
	logic [RADIX_W-1:0]  radix_q;
	logic [RADIX_W-1:0]  base_q;
	logic [PAD_W-1:0]    quo_q;
	logic [DIGIT_W-1:0]  rem_q;
	logic [STEP_W-1:0]   step_q;
	logic [ADDR_W-1:0]   ndig_q;
	logic [ADDR_W-1:0]   rd_addr_q;
	logic [DIGIT_W-1:0]  rdata_q;
	logic                last_q;

	logic [DIGIT_W-1:0]  digit_mem [VALUE_BITS];

	logic [RADIX_W-1:0]  base_clamped;
	logic [PAD_W-1:0]    quo_nxt;
	logic [DIGIT_W-1:0]  rem_nxt;
	logic [DIGIT_W:0]    trial;
	logic                step_last;
	logic                wr_en;

	always_comb begin
		if (radix_q < RADIX_MIN)
			base_clamped = RADIX_MIN;
		else if (radix_q > RADIX_MAX)
			base_clamped = RADIX_MAX;
		else
			base_clamped = radix_q;
	end

	// Shared divide unit: DIV_BITS restoring steps per cycle, remainder stays below base.
	always_comb begin
		rem_nxt = rem_q;
		quo_nxt = quo_q;
		trial   = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial   = {rem_nxt, quo_nxt[PAD_W-1]};
			quo_nxt = {quo_nxt[PAD_W-2:0], 1'b0};
			if (trial >= {1'b0, base_q}) begin
				trial      = trial - {1'b0, base_q};
				quo_nxt[0] = 1'b1;
			end
			rem_nxt = trial[DIGIT_W-1:0];
		end
	end

	assign step_last = (step_q == STEP_W'(STEPS - 1));
	assign wr_en     = (state_q == S_DIV) && step_last;

	assign number.ready       = (state_q == S_IDLE);
	assign digits.valid       = (state_q == S_SEND);
	assign digits.digit_value = rdata_q;
	assign digits.digit_char  = digit_to_char(rdata_q);
	assign digits.last_digit  = last_q;

	// Digits are stored LSD first and read back in reverse.
	always_ff @(posedge clk) begin
		if (wr_en)
			digit_mem[ndig_q] <= rem_nxt;
		if (state_q == S_READ)
			rdata_q <= digit_mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			radix_q   <= RADIX_RESET;
			base_q    <= RADIX_RESET;
			quo_q     <= '0;
			rem_q     <= '0;
			step_q    <= '0;
			ndig_q    <= '0;
			rd_addr_q <= '0;
			last_q    <= 1'b0;
		end else begin
			if (cfg_we)
				radix_q <= cfg_wdata;
			case (state_q)
				S_IDLE: begin
					if (number.valid) begin
						base_q  <= base_clamped;
						quo_q   <= PAD_W'(number.value[VALUE_BITS-1:0]);
						rem_q   <= '0;
						step_q  <= '0;
						ndig_q  <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					quo_q <= quo_nxt;
					if (step_last) begin
						rem_q  <= '0;
						step_q <= '0;
						ndig_q <= ndig_q + 1'b1;
						if (quo_nxt == '0) begin
							rd_addr_q <= ndig_q;
							state_q   <= S_READ;
						end
					end else begin
						rem_q  <= rem_nxt;
						step_q <= step_q + 1'b1;
					end
				end
				S_READ: begin
					last_q  <= (rd_addr_q == '0);
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (digits.ready) begin
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							rd_addr_q <= rd_addr_q - 1'b1;
							state_q   <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/itrd_checker.sv =====
// Port-level checks for the radix digit converter, bound to its top level.
// Depends on itrd_pkg and the macros in integer_to_radix_digits_assert.svh.
`include "integer_to_radix_digits_assert.svh"

module itrd_checker import itrd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [CHAR_W-1:0]  digit_char,
	input logic [DIGIT_W-1:0] digit_value,
	input logic               last_digit
);

	`ITRD_ASSERT(a_busy_excl, !(in_ready && out_valid), "ready for a request while sending digits")
	`ITRD_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready right after a request")
	`ITRD_ASSERT_NEXT(a_hold, out_valid && !out_ready,
		out_valid && $stable(digit_value) && $stable(last_digit), "stalled digit changed")
	`ITRD_ASSERT(a_alphabet, !out_valid ||
		(digit_value < 6'd10 && digit_char == 7'd48 + 7'(digit_value)) ||
		(digit_value >= 6'd10 && digit_value < 6'd36 && digit_char == 7'd55 + 7'(digit_value)) ||
		(digit_value >= 6'd36 && digit_char == 7'd61 + 7'(digit_value)),
		"digit character does not match digit value")
	`ITRD_ASSERT_NEXT(a_end, out_valid && out_ready && last_digit, !out_valid,
		"digit sent after the last one")

endmodule

bind integer_to_radix_digits itrd_checker u_itrd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (number.valid),
	.in_ready    (number.ready),
	.out_valid   (digits.valid),
	.out_ready   (digits.ready),
	.digit_char  (digits.digit_char),
	.digit_value (digits.digit_value),
	.last_digit  (digits.last_digit)
);
